// ===== rtl/ulebd_pkg.sv =====
// ----------------------------------------------------------------------------
// ulebd_pkg
// Shared types and constants for the ULEB128 delta address decoder: phase
// and status codes, configuration register indexes, decoder state and the
// result item format.
// ----------------------------------------------------------------------------
package ulebd_pkg;

	// Width of addresses, offsets and deltas.
	localparam int unsigned ADDR_W = 64;

	// Bytes of one delta that are accepted before the delta counts as malformed.
	localparam int unsigned BYTE_CNT_W = 4;
	localparam logic [BYTE_CNT_W-1:0] MAX_DELTA_BYTES = BYTE_CNT_W'(10);

	// Default depth of the result queue.
	localparam int unsigned OUTQ_DEPTH = 4;

	// Result kinds.
	localparam logic KIND_ADDRESS = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef enum logic [1:0] {
		PH_DECODE = 2'd0,
		PH_PAD    = 2'd1,
		PH_DRAIN  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_MALFORMED = 3'd1,
		ST_PADDING   = 3'd2,
		ST_LIMIT     = 3'd3,
		ST_UNTERM    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_LOAD_ADDRESS = 2'd0,
		CFG_MAX_OFFSET   = 2'd1,
		CFG_CHECK_ENABLE = 2'd2
	} cfg_index_t;

	// Decoder state carried from one byte to the next. The base address is
	// kept as load address plus running offset so that an emitted address
	// needs only one add.
	typedef struct packed {
		phase_t                phase;
		logic [ADDR_W-1:0]     partial;
		logic [BYTE_CNT_W-1:0] byte_cnt;
		logic [ADDR_W-1:0]     offset;
		logic [ADDR_W-1:0]     base_addr;
		status_t               saved;
	} dec_state_t;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] address;
		status_t           status;
		logic              final_res;
	} result_t;

	// Results of one byte: up to two, the first always in slot one.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} step_res_t;

endpackage

// ===== rtl/ulebd_step.sv =====
// ----------------------------------------------------------------------------
// ulebd_step
// Decodes one blob byte against the current decoder state: assembles the
// LEB128 delta, updates the running offset, checks limit and padding and
// forms up to two result items together with the next state.
// ----------------------------------------------------------------------------
module ulebd_step (
	input  ulebd_pkg::dec_state_t       cur,
	input  logic [7:0]                  data_byte,
	input  logic                        blob_end,
	input  logic [ulebd_pkg::ADDR_W-1:0] load_address,
	input  logic [ulebd_pkg::ADDR_W-1:0] max_offset,
	input  logic                        check_enable,
	output ulebd_pkg::dec_state_t       nxt,
	output ulebd_pkg::step_res_t        res
);
	import ulebd_pkg::*;

	logic [6:0]        shamt;
	logic [ADDR_W-1:0] group_bits;
	logic [ADDR_W-1:0] delta;
	logic [ADDR_W-1:0] new_offset;
	logic [ADDR_W-1:0] new_addr;

	// Value bits of this byte placed at the current bit position (7 per byte).
	assign shamt      = {cur.byte_cnt, 3'b000} - 7'(cur.byte_cnt);
	assign group_bits = ADDR_W'(data_byte[6:0]) << shamt;
	assign delta      = cur.partial | group_bits;
	assign new_offset = cur.offset + delta;
	assign new_addr   = cur.base_addr + delta;

	// Next state and results for this byte.
	always_comb begin
		logic    emit_addr;
		logic    emit_stat;
		status_t stat_code;
		result_t addr_res;
		result_t stat_res;

		emit_addr = 1'b0;
		emit_stat = 1'b0;
		stat_code = ST_OK;
		nxt       = cur;

		case (cur.phase)
			PH_PAD: begin
				if (check_enable && (data_byte != 8'd0)) begin
					emit_stat = 1'b1;
					stat_code = ST_PADDING;
				end else if (blob_end) begin
					emit_stat = 1'b1;
					stat_code = ST_OK;
				end
			end
			PH_DECODE: begin
				if (cur.byte_cnt >= MAX_DELTA_BYTES) begin
					emit_stat = 1'b1;
					stat_code = ST_MALFORMED;
				end else if (data_byte[7]) begin
					// Delta continues; an open delta at the blob's end is malformed.
					nxt.partial  = delta;
					nxt.byte_cnt = cur.byte_cnt + 1'b1;
					if (blob_end) begin
						emit_stat = 1'b1;
						stat_code = ST_MALFORMED;
					end
				end else begin
					nxt.partial  = '0;
					nxt.byte_cnt = '0;
					if (delta == '0) begin
						// Terminator: the rest of the blob is padding.
						nxt.phase = PH_PAD;
						if (blob_end) begin
							emit_stat = 1'b1;
							stat_code = ST_OK;
						end
					end else begin
						nxt.offset    = new_offset;
						nxt.base_addr = new_addr;
						if (check_enable && (new_offset > max_offset)) begin
							emit_stat = 1'b1;
							stat_code = ST_LIMIT;
						end else begin
							emit_addr = 1'b1;
							if (blob_end) begin
								emit_stat = 1'b1;
								stat_code = ST_UNTERM;
							end
						end
					end
				end
			end
			default: begin
				// Draining after an early error: the final byte repeats it.
				if (blob_end) begin
					emit_stat = 1'b1;
					stat_code = cur.saved;
				end
			end
		endcase

		// A status closes the blob on its final byte, else the block drains.
		if (emit_stat) begin
			if (blob_end) begin
				nxt.phase     = PH_DECODE;
				nxt.partial   = '0;
				nxt.byte_cnt  = '0;
				nxt.offset    = '0;
				nxt.base_addr = load_address;
				nxt.saved     = ST_OK;
			end else begin
				nxt.phase = PH_DRAIN;
				nxt.saved = stat_code;
			end
		end

		addr_res.kind      = KIND_ADDRESS;
		addr_res.address   = new_addr;
		addr_res.status    = ST_OK;
		addr_res.final_res = 1'b0;

		stat_res.kind      = KIND_STATUS;
		stat_res.address   = '0;
		stat_res.status    = stat_code;
		stat_res.final_res = blob_end;

		res.first  = emit_addr ? addr_res : stat_res;
		res.second = stat_res;
		res.count  = {1'b0, emit_addr} + {1'b0, emit_stat};
	end

endmodule

// ===== rtl/ulebd_outq.sv =====
// ----------------------------------------------------------------------------
// ulebd_outq
// Small result queue that takes up to two result items a cycle and hands
// them out one at a time over a valid/ready channel.
// ----------------------------------------------------------------------------
module ulebd_outq #(
	parameter int unsigned Depth = ulebd_pkg::OUTQ_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_count,
	input  ulebd_pkg::result_t  push_first,
	input  ulebd_pkg::result_t  push_second,
	output logic                room_for_two,
	output logic                out_valid,
	input  logic                out_ready,
	output ulebd_pkg::result_t  head
);
	import ulebd_pkg::*;

	localparam int unsigned PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CNT_W = $clog2(Depth + 1);

	result_t           mem [Depth];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [PTR_W-1:0]  wr_next;
	logic              pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_next      = ptr_inc(wr_ptr_q);
	assign pop          = out_valid && out_ready;
	assign out_valid    = (count_q != '0);
	assign room_for_two = (count_q <= CNT_W'(Depth - 2));
	assign head         = mem[rd_ptr_q];

	// Storage: one or two entries written per cycle.
	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem[wr_ptr_q] <= push_first;
		end
		if (push_count == 2'd2) begin
			mem[wr_next] <= push_second;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_count == 2'd2) begin
				wr_ptr_q <= ptr_inc(wr_next);
			end else if (push_count == 2'd1) begin
				wr_ptr_q <= wr_next;
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CNT_W'(push_count) - CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/uleb_delta_address_decoder.sv =====
// ----------------------------------------------------------------------------
// uleb_delta_address_decoder
// Decodes a blob of ULEB128 deltas into absolute addresses with a closing
// status for every blob.
// ----------------------------------------------------------------------------
// Each byte is taken into an input register and decoded from it once the
// queue has room; the results (none, one or two per byte) go into a small
// queue that feeds the output channel. With the output taken promptly the
// block accepts one byte every clock cycle, and a byte's first result passes
// through the input register and the queue before it reaches the output.
// A byte waits in the input register only while the queue cannot take two
// more results, so throughput is set by how fast the consumer drains the
// queue. Registers may be written only while no blob result is outstanding;
// a load address written mid-blob applies to the following addresses.
module uleb_delta_address_decoder #(
	parameter int unsigned OutqDepth = ulebd_pkg::OUTQ_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  data_byte,
	input  logic                        blob_end,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        result_kind,
	output logic [ulebd_pkg::ADDR_W-1:0] address,
	output logic [2:0]                  status,
	output logic                        final_res,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [ulebd_pkg::ADDR_W-1:0] cfg_wdata
);
	import ulebd_pkg::*;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic [ADDR_W-1:0] load_address_q;
	logic [ADDR_W-1:0] max_offset_q;
	logic              check_enable_q;
	dec_state_t        state_q;
	dec_state_t        state_next;
	step_res_t         step_res;
	logic              room_for_two;
	logic              take_s1;
	logic [1:0]        push_count;
	result_t           head;

	// A byte is decoded once the queue can hold both of its possible results.
	assign take_s1    = valid_s1 && room_for_two;
	assign in_ready   = !valid_s1 || take_s1;
	assign push_count = take_s1 ? step_res.count : 2'd0;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= blob_end;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_address_q <= '0;
			max_offset_q   <= '1;
			check_enable_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOAD_ADDRESS: load_address_q <= cfg_wdata;
				CFG_MAX_OFFSET:   max_offset_q   <= cfg_wdata;
				CFG_CHECK_ENABLE: check_enable_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Decoder state; a new load address rebuilds the base address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= PH_DECODE;
			state_q.partial   <= '0;
			state_q.byte_cnt  <= '0;
			state_q.offset    <= '0;
			state_q.base_addr <= '0;
			state_q.saved     <= ST_OK;
		end else if (cfg_we && (cfg_index == CFG_LOAD_ADDRESS)) begin
			state_q.base_addr <= cfg_wdata + state_q.offset;
		end else if (take_s1) begin
			state_q <= state_next;
		end
	end

	ulebd_step u_step (
		.cur          (state_q),
		.data_byte    (byte_s1),
		.blob_end     (last_s1),
		.load_address (load_address_q),
		.max_offset   (max_offset_q),
		.check_enable (check_enable_q),
		.nxt          (state_next),
		.res          (step_res)
	);

	ulebd_outq #(
		.Depth (OutqDepth)
	) u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_count   (push_count),
		.push_first   (step_res.first),
		.push_second  (step_res.second),
		.room_for_two (room_for_two),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.head         (head)
	);

	assign result_kind = head.kind;
	assign address     = head.address;
	assign status      = head.status;
	assign final_res   = head.final_res;

endmodule

// ===== rtl/ulebd_checker.sv =====
// ----------------------------------------------------------------------------
// ulebd_checker
// Port-level checks for the ULEB128 delta address decoder, bound to the top
// level.
// ----------------------------------------------------------------------------
module ulebd_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic                        result_kind,
	input  logic [ulebd_pkg::ADDR_W-1:0] address,
	input  logic [2:0]                  status,
	input  logic                        final_res
);
	import ulebd_pkg::*;

	// A stalled result request keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
		$stable(address) && $stable(status) && $stable(final_res))
		else $error("result request changed while stalled");

	// Address results carry no status and never close a blob.
	a_addr_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_ADDRESS) |-> (status == ST_OK) && !final_res)
		else $error("address result with status or final flag");

	// Status results carry a defined code and a zero address.
	a_stat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_STATUS) |->
		(status <= ST_UNTERM) && (address == '0))
		else $error("malformed status result");

	// No result is presented straight after reset.
	a_no_early_out: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result presented straight after reset");

endmodule

bind uleb_delta_address_decoder ulebd_checker u_ulebd_checker (.*);
